@@ rtl/twcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package twcs_pkg;

    localparam int DEFAULT_RING_DEPTH = 64;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARA_WINDOW = 2'd2;

    localparam logic [5:0] MAX_TOKENS_RESET  = 6'd63;
    localparam logic [5:0] OVERLAP_RESET     = 6'd0;
    localparam logic [5:0] PARA_WINDOW_RESET = 6'd0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CFG = 1'b1;

    typedef struct packed {
        logic [15:0] paragraph_index;
        logic [31:0] token_begin;
        logic [31:0] token_end;
        logic        last_token;
    } in_word_t;

    typedef struct packed {
        logic        status;
        logic [15:0] chunk_sequence;
        logic [31:0] chunk_start;
        logic [5:0]  chunk_length;
        logic [31:0] span_begin;
        logic [31:0] span_end;
        logic        final_chunk;
        logic        run_last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] paragraph;
        logic [31:0] tok_begin;
        logic [31:0] tok_end;
    } ring_entry_t;

endpackage

`default_nettype wire

@@ rtl/token_window_chunk_segmenter_top.sv @@
// a token that closes no chunk is written to the ring and checked, then the block is idle again;
// a chunk it closes passes through SFIRST and the backward paragraph search, which reads one
// ring entry per cycle over the search window, then two reads for the span and the build
// a new token is taken only in idle, after every chunk it closes is built; a flush chunk
// skips the search; a result waiting on the output holds the input
// reset: synchronous, active low; control and settings registers return to defaults and the document
// counters clear; ring contents are left as they are and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module token_window_chunk_segmenter_top #(
    parameter int RING_DEPTH = twcs_pkg::DEFAULT_RING_DEPTH
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  twcs_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output twcs_pkg::out_word_t               m_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [twcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [twcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import twcs_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    ring_entry_t       wr_data;
    logic [SLOT_W-1:0] rd_addr;
    ring_entry_t       rd_data;

    twcs_ctrl #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    twcs_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

@@ rtl/twcs_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none

module twcs_ring #(
    parameter int RING_DEPTH = twcs_pkg::DEFAULT_RING_DEPTH
) (
    input  wire                               aclk,
    input  wire                               wr_en,
    input  wire [$clog2(RING_DEPTH)-1:0]      wr_addr,
    input  twcs_pkg::ring_entry_t             wr_data,
    input  wire [$clog2(RING_DEPTH)-1:0]      rd_addr,
    output twcs_pkg::ring_entry_t             rd_data
);
    import twcs_pkg::*;

    ring_entry_t mem [RING_DEPTH];
    ring_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/twcs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module twcs_ctrl #(
    parameter int RING_DEPTH = twcs_pkg::DEFAULT_RING_DEPTH
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  twcs_pkg::in_word_t                    s_data,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output twcs_pkg::out_word_t                   m_data,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [twcs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [twcs_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]         wr_addr,
    output twcs_pkg::ring_entry_t                 wr_data,
    output logic [$clog2(RING_DEPTH)-1:0]         rd_addr,
    input  twcs_pkg::ring_entry_t                 rd_data
);
    import twcs_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > 6) ? CNT_W : 6) + 2;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_SFIRST = 8'b0000_0100,
        ST_SEARCH = 8'b0000_1000,
        ST_FBEGIN = 8'b0001_0000,
        ST_FEND   = 8'b0010_0000,
        ST_BUILD  = 8'b0100_0000,
        ST_ERROR  = 8'b1000_0000
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [5:0] k);
        logic [CMP_W-1:0] sum;
        sum = CMP_W'(base) + CMP_W'(k);
        if (sum >= CMP_W'(RING_DEPTH)) begin
            sum = sum - CMP_W'(RING_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [5:0]        max_reg, max_next;
    logic [5:0]        ovl_reg, ovl_next;
    logic [5:0]        pwin_reg, pwin_next;
    logic [31:0]       start_index_reg, start_index_next;
    logic [15:0]       seq_reg, seq_next;
    logic [CNT_W-1:0]  pending_reg, pending_next;
    logic [SLOT_W-1:0] start_slot_reg, start_slot_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic              last_reg, last_next;
    logic              flush_reg, flush_next;
    logic              out_valid_reg, out_valid_next;
    logic [5:0]        probe_reg, probe_next;
    logic [5:0]        len_reg, len_next;
    logic [15:0]       held_par_reg, held_par_next;
    logic [31:0]       src_begin_reg, src_begin_next;
    out_word_t         out_data_reg, out_data_next;

    logic              settings_ok;
    logic              out_free;
    logic [5:0]        lo;
    logic [5:0]        adv;
    logic [5:0]        rd_k;
    logic [CMP_W-1:0]  pending_left;

    assign settings_ok = (max_reg != 6'd0) && (ovl_reg < max_reg) && (pwin_reg <= max_reg)
                         && (CMP_W'(max_reg) < CMP_W'(RING_DEPTH));
    assign out_free    = !out_valid_reg || m_ready;
    assign lo          = (max_reg > pwin_reg) ? (max_reg - pwin_reg) : 6'd1;
    assign adv         = (len_reg > ovl_reg) ? (len_reg - ovl_reg) : 6'd1;
    assign pending_left = CMP_W'(pending_reg) - CMP_W'(adv);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign wr_addr              = write_slot_reg;
    assign wr_data.paragraph    = s_data.paragraph_index;
    assign wr_data.tok_begin    = s_data.token_begin;
    assign wr_data.tok_end      = s_data.token_end;

    always_comb begin
        unique case (state_reg) inside
            ST_CHECK:          rd_k = max_reg;
            ST_SFIRST:         rd_k = probe_reg - 6'd1;
            ST_SEARCH:         rd_k = (probe_reg >= 6'd2) ? (probe_reg - 6'd2) : 6'd0;
            ST_FEND, ST_BUILD: rd_k = len_reg - 6'd1;
            default:           rd_k = 6'd0;
        endcase
    end

    assign rd_addr = slot_add(start_slot_reg, rd_k);

    always_comb begin
        max_next         = max_reg;
        ovl_next         = ovl_reg;
        pwin_next        = pwin_reg;
        state_next       = state_reg;
        start_index_next = start_index_reg;
        seq_next         = seq_reg;
        pending_next     = pending_reg;
        start_slot_next  = start_slot_reg;
        write_slot_next  = write_slot_reg;
        last_next        = last_reg;
        flush_next       = flush_reg;
        probe_next       = probe_reg;
        len_next         = len_reg;
        held_par_next    = held_par_reg;
        src_begin_next   = src_begin_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg;
        wr_en            = 1'b0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_TOKENS:  max_next  = cfg_data;
                REG_OVERLAP:     ovl_next  = cfg_data;
                REG_PARA_WINDOW: pwin_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next = s_data.last_token;
                    if (settings_ok) begin
                        wr_en           = 1'b1;
                        write_slot_next = slot_add(write_slot_reg, 6'd1);
                        pending_next    = pending_reg + CNT_W'(1);
                        state_next      = ST_CHECK;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
            end
            ST_CHECK: begin
                if (CMP_W'(pending_reg) > CMP_W'(max_reg)) begin
                    probe_next = max_reg;
                    flush_next = 1'b0;
                    state_next = ST_SFIRST;
                end else if (last_reg) begin
                    len_next   = 6'(pending_reg);
                    flush_next = 1'b1;
                    state_next = ST_FBEGIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SFIRST: begin
                held_par_next = rd_data.paragraph;
                state_next    = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (rd_data.paragraph != held_par_reg) begin
                    len_next   = probe_reg;
                    state_next = ST_FBEGIN;
                end else if (probe_reg > lo) begin
                    held_par_next = rd_data.paragraph;
                    probe_next    = probe_reg - 6'd1;
                end else begin
                    len_next   = max_reg;
                    state_next = ST_FBEGIN;
                end
            end
            ST_FBEGIN: begin
                state_next = ST_FEND;
            end
            ST_FEND: begin
                src_begin_next = rd_data.tok_begin;
                state_next     = ST_BUILD;
            end
            ST_BUILD: begin
                if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.status         = STATUS_OK;
                    out_data_next.chunk_sequence = seq_reg;
                    out_data_next.chunk_start    = start_index_reg;
                    out_data_next.chunk_length   = len_reg;
                    out_data_next.span_begin     = src_begin_reg;
                    out_data_next.span_end       = rd_data.tok_end;
                    out_data_next.final_chunk    = flush_reg;
                    if (flush_reg) begin
                        out_data_next.run_last = 1'b1;
                        start_index_next       = 32'd0;
                        seq_next               = 16'd0;
                        pending_next           = '0;
                        start_slot_next        = '0;
                        write_slot_next        = '0;
                        state_next             = ST_IDLE;
                    end else begin
                        out_data_next.run_last = (pending_left <= CMP_W'(max_reg)) && !last_reg;
                        start_index_next       = start_index_reg + 32'(adv);
                        seq_next               = seq_reg + 16'd1;
                        pending_next           = pending_left[CNT_W-1:0];
                        start_slot_next        = slot_add(start_slot_reg, adv);
                        state_next             = ST_CHECK;
                    end
                end
            end
            ST_ERROR: begin
                if (out_free) begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = STATUS_BAD_CFG;
                    out_data_next.chunk_sequence = 16'd0;
                    out_data_next.chunk_start    = 32'd0;
                    out_data_next.chunk_length   = 6'd0;
                    out_data_next.span_begin     = 32'd0;
                    out_data_next.span_end       = 32'd0;
                    out_data_next.final_chunk    = last_reg;
                    out_data_next.run_last       = 1'b1;
                    if (last_reg) begin
                        start_index_next = 32'd0;
                        seq_next         = 16'd0;
                        pending_next     = '0;
                        start_slot_next  = '0;
                        write_slot_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_reg         <= MAX_TOKENS_RESET;
            ovl_reg         <= OVERLAP_RESET;
            pwin_reg        <= PARA_WINDOW_RESET;
            start_index_reg <= 32'd0;
            seq_reg         <= 16'd0;
            pending_reg     <= '0;
            start_slot_reg  <= '0;
            write_slot_reg  <= '0;
            last_reg        <= 1'b0;
            flush_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            max_reg         <= max_next;
            ovl_reg         <= ovl_next;
            pwin_reg        <= pwin_next;
            start_index_reg <= start_index_next;
            seq_reg         <= seq_next;
            pending_reg     <= pending_next;
            start_slot_reg  <= start_slot_next;
            write_slot_reg  <= write_slot_next;
            last_reg        <= last_next;
            flush_reg       <= flush_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg     <= probe_next;
        len_reg       <= len_next;
        held_par_reg  <= held_par_next;
        src_begin_reg <= src_begin_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire
